// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the solver RTL.
// Each use stands on a line of its own, with a label, a property and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check on every clock edge, ignored while reset is active.
`define JLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check on every clock edge, reset included.
`define JLS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define JLS_ASSERT(lbl, prop, msg)
`define JLS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/jls_pkg.sv -----
`timescale 1ns / 1ps
package jls_pkg;

  localparam int MAX_UNKNOWNS_DEF = 16;
  localparam int VALUE_BITS_DEF   = 32;
  localparam int FRAC_BITS        = 16;
  // Numerator magnitude bits plus the fraction shift, for the default sizes.
  localparam int DIV_BITS_DEF     = VALUE_BITS_DEF + $clog2(MAX_UNKNOWNS_DEF) + 2 + FRAC_BITS;

  localparam logic [4:0]  SIZE_RST  = 5'd16;
  localparam logic [30:0] TOL_RST   = 31'd1;
  localparam logic [15:0] MAXIT_RST = 16'd1000;
  localparam int          OUT_CAP   = 16;

  localparam logic [1:0] ACT_COEF  = 2'd0;
  localparam logic [1:0] ACT_RHS   = 2'd1;
  localparam logic [1:0] ACT_SOLVE = 2'd2;

  localparam logic [1:0] REG_SIZE  = 2'd0;
  localparam logic [1:0] REG_TOL   = 2'd1;
  localparam logic [1:0] REG_MAXIT = 2'd2;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } jls_op_e;

  typedef struct packed {
    logic    start;
    jls_op_e op;
  } jls_cmd_t;

endpackage

// ----- rtl/jls_unit.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Shared serial arithmetic: shift-add multiply, restoring divide, bitwise square root.
module jls_unit #(
  parameter int V  = jls_pkg::VALUE_BITS_DEF,
  parameter int NW = jls_pkg::DIV_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  jls_pkg::jls_cmd_t                      cmd_i,
  input  logic [((NW > 64) ? NW : 64)-1:0]       a_i,
  input  logic [V-1:0]                           b_i,
  output logic                                   done_o,
  output logic [((2*V > ((NW > 64) ? NW : 64)) ? 2*V : ((NW > 64) ? NW : 64))-1:0] res_o
);

  localparam int A_W   = (NW > 64) ? NW : 64;
  localparam int R_W   = (2 * V > A_W) ? 2 * V : A_W;
  localparam int CNT_W = $clog2(A_W + 1);

  logic                 busy_q;
  logic                 done_q;
  jls_pkg::jls_op_e     op_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [CNT_W-1:0]     last_cnt;

  logic [2*V-1:0]       pr_q, pr_d;
  logic [V-1:0]         mc_q;
  logic [V:0]           mul_sum;

  logic [V-1:0]         rem_q, rem_d, dv_q;
  logic [NW-1:0]        quo_q, quo_d;
  logic [V:0]           div_t, div_r;
  logic                 div_ge;

  logic [63:0]          sv_q, sv_d, sr_q, sr_d, sb_q, sq_t;
  logic                 sq_ge;

  always_comb begin
    mul_sum = {1'b0, pr_q[2*V-1:V]} + (pr_q[0] ? {1'b0, mc_q} : {(V+1){1'b0}});
    pr_d    = {mul_sum, pr_q[V-1:1]};

    div_t   = {rem_q, quo_q[NW-1]};
    div_ge  = (div_t >= {1'b0, dv_q});
    div_r   = div_ge ? (div_t - {1'b0, dv_q}) : div_t;
    rem_d   = div_r[V-1:0];
    quo_d   = {quo_q[NW-2:0], div_ge};

    sq_t    = sr_q + sb_q;
    sq_ge   = (sv_q >= sq_t);
    sv_d    = sq_ge ? (sv_q - sq_t) : sv_q;
    sr_d    = sq_ge ? ((sr_q >> 1) + sb_q) : (sr_q >> 1);
  end

  always_comb begin
    unique case (op_q)
      jls_pkg::OP_MUL:  last_cnt = CNT_W'(V - 1);
      jls_pkg::OP_DIV:  last_cnt = CNT_W'(NW - 1);
      jls_pkg::OP_SQRT: last_cnt = CNT_W'(31);
      default:          last_cnt = '0;
    endcase
  end

  always_comb begin
    unique case (op_q)
      jls_pkg::OP_MUL:  res_o = R_W'(pr_q);
      jls_pkg::OP_DIV:  res_o = R_W'(quo_q);
      jls_pkg::OP_SQRT: res_o = R_W'(sr_q);
      default:          res_o = '0;
    endcase
  end

  assign done_o = done_q;

  // Control: one operation at a time, done pulses after the final step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= jls_pkg::OP_MUL;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        op_q   <= cmd_i.op;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == last_cnt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands on start, then advance one step a cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pr_q  <= {{V{1'b0}}, a_i[V-1:0]};
      mc_q  <= b_i;
      rem_q <= '0;
      quo_q <= a_i[NW-1:0];
      dv_q  <= b_i;
      sv_q  <= a_i[63:0];
      sr_q  <= '0;
      sb_q  <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      unique case (op_q)
        jls_pkg::OP_MUL: pr_q <= pr_d;
        jls_pkg::OP_DIV: begin
          rem_q <= rem_d;
          quo_q <= quo_d;
        end
        jls_pkg::OP_SQRT: begin
          sv_q <= sv_d;
          sr_q <= sr_d;
          sb_q <= sb_q >> 2;
        end
        default: pr_q <= pr_q;
      endcase
    end
  end

  `JLS_ASSERT(a_start_idle, cmd_i.start |-> !busy_q, "operation started while unit busy")
  `JLS_ASSERT(a_done_free, done_q |-> !busy_q, "done raised while unit still busy")

endmodule

// ----- rtl/jacobi_linear_solver.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Jacobi solver for A x = b in signed Q16.16. Load requests (matrix entry, right-hand-side
// entry) write straight into the stores and the block is ready again on the next cycle. A solve
// request holds in_stall_o high until all n solution elements have been handed out: it starts
// from x = 0 and runs Jacobi sweeps on one shared serial unit (multiply, divide, square root),
// whose divide works on DIV_BITS = VALUE_BITS + log2(MAX_UNKNOWNS) + 18 bits; on the first
// sweep the products vanish and no multiply is started before the divide. After the last
// sweep each solution element is read, loaded into the output register and held until it is
// taken. The run ends when the vector norms of two sweeps differ by less than the tolerance
// register, or after max_iterations sweeps. A zero diagonal sets divide_fault and saturates
// that element. Configuration goes through the APB port (byte addresses 0, 4, 8); the user
// must write it only while idle, which the block itself does not enforce.
module jacobi_linear_solver #(
  parameter int MAX_UNKNOWNS = jls_pkg::MAX_UNKNOWNS_DEF,
  parameter int VALUE_BITS   = jls_pkg::VALUE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [3:0]  row_i,
  input  logic [3:0]  column_i,
  input  logic [31:0] entry_value_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  index_o,
  output logic [31:0] solution_value_o,
  output logic        last_o,
  output logic        converged_o,
  output logic        divide_fault_o,
  output logic [15:0] iterations_used_o
);

  localparam int V     = VALUE_BITS;
  localparam int IDX_W = $clog2(MAX_UNKNOWNS);
  localparam int ACC_W = V + IDX_W + 2;
  localparam int NW    = ACC_W + jls_pkg::FRAC_BITS;
  localparam int A_W   = (NW > 64) ? NW : 64;
  localparam int R_W   = (2 * V > A_W) ? 2 * V : A_W;
  localparam int SQ_W  = (2 * V > 64) ? 2 * V : 64;
  localparam int EXT_W = ((V > 32) ? V : 32) + 1;
  localparam int CAP   = (MAX_UNKNOWNS < jls_pkg::OUT_CAP) ? MAX_UNKNOWNS : jls_pkg::OUT_CAP;

  localparam logic [4:0]       CAP_V  = 5'(CAP);
  localparam logic [V-1:0]     VMAX_V = {1'b0, {(V-1){1'b1}}};
  localparam logic [V-1:0]     VMIN_V = {1'b1, {(V-1){1'b0}}};
  localparam logic [EXT_W-1:0] VMAX_E = {{(EXT_W-V+1){1'b0}}, {(V-1){1'b1}}};
  localparam logic [EXT_W-1:0] VMIN_E = {{(EXT_W-V+1){1'b1}}, {(V-1){1'b0}}};
  localparam logic [EXT_W-1:0] OMAX_E = {{(EXT_W-31){1'b0}}, {31{1'b1}}};
  localparam logic [EXT_W-1:0] OMIN_E = {{(EXT_W-31){1'b1}}, {31{1'b0}}};

  // Sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RD    = 4'd1;   // issue A[i][j] and x[j] reads
  localparam logic [3:0] ST_OP    = 4'd2;   // read data back: take diagonal or start product
  localparam logic [3:0] ST_MUL   = 4'd3;   // wait for product, accumulate
  localparam logic [3:0] ST_NUM   = 4'd4;   // form b[i] - sum, start divide
  localparam logic [3:0] ST_DIV   = 4'd5;   // wait for quotient
  localparam logic [3:0] ST_WR    = 4'd6;   // store new x[i], start its square
  localparam logic [3:0] ST_SQ    = 4'd7;   // accumulate square into the norm sum
  localparam logic [3:0] ST_NORM  = 4'd8;   // start square root of the sum
  localparam logic [3:0] ST_SQRT  = 4'd9;   // convergence test, next sweep or finish
  localparam logic [3:0] ST_ERD   = 4'd10;  // issue read of one solution element
  localparam logic [3:0] ST_EOUT  = 4'd11;  // load the output register
  localparam logic [3:0] ST_EHOLD = 4'd12;  // hold until the result is taken

  // Configuration registers
  logic [4:0]  size_q;
  logic [30:0] tol_q;
  logic [15:0] maxit_q;
  logic        cfg_wr;

  // Sequencer and datapath state
  logic [3:0]        st_q;
  logic [IDX_W-1:0]  i_q, j_q, n_m1_q;
  logic              bank_q, first_q, neg_q, conv_q, fault_q;
  logic [ACC_W-1:0]  acc_q;
  logic [V-1:0]      diag_q, res_q;
  logic [63:0]       s_q;
  logic [31:0]       prev_norm_q;
  logic [15:0]       sweep_q;
  logic              out_valid_q;
  logic [31:0]       out_val_q;

  // Memories
  logic [V-1:0] coef_mem [(1 << (2 * IDX_W))];
  logic [V-1:0] rhs_mem  [(1 << IDX_W)];
  logic [V-1:0] est_mem  [(2 << IDX_W)];
  logic [V-1:0] coef_rd, rhs_rd, est_rd;
  logic         coef_we, rhs_we, est_we;
  logic [2*IDX_W-1:0] coef_waddr, coef_raddr;
  logic [IDX_W:0]     est_raddr;

  // Shared unit
  jls_pkg::jls_cmd_t unit_cmd;
  logic [A_W-1:0]    unit_a;
  logic [V-1:0]      unit_b;
  logic              unit_done;
  logic [R_W-1:0]    unit_res;

  // Combinational helpers
  logic              in_acc, row_ok, col_ok;
  logic [EXT_W-1:0]  ev_ext, xo_ext;
  logic [V-1:0]      ev_sat, x_cur, x_mag, coef_mag, res_mag, diag_mag, lim_v;
  logic [2*V-17:0]   mul_pm;
  logic [V-1:0]      mul_mag, prod_s;
  logic [NW-1:0]     div_q;
  logic [V-1:0]      div_mag, quot_s;
  logic [ACC_W-1:0]  num_w, num_mag;
  logic [SQ_W-1:0]   sq_ext;
  logic [63:0]       sq64;
  logic [64:0]       s_sum;
  logic [63:0]       s_d;
  logic [31:0]       new_norm, norm_diff;
  logic              conv_hit, last_sweep;
  logic [4:0]        sz_eff, n_eff;
  logic [IDX_W-1:0]  n_m1_d;
  logic [31:0]       out_sat;

  // ---------------------------------------------------------------------------------------
  // Configuration port: always ready.
  // ---------------------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= jls_pkg::SIZE_RST;
      tol_q   <= jls_pkg::TOL_RST;
      maxit_q <= jls_pkg::MAXIT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        jls_pkg::REG_SIZE:  size_q  <= pwdata[4:0];
        jls_pkg::REG_TOL:   tol_q   <= pwdata[30:0];
        jls_pkg::REG_MAXIT: maxit_q <= pwdata[15:0];
        default:            size_q  <= size_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      jls_pkg::REG_SIZE:  prdata = 32'(size_q);
      jls_pkg::REG_TOL:   prdata = 32'(tol_q);
      jls_pkg::REG_MAXIT: prdata = 32'(maxit_q);
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Request side: loads write straight into the stores; indexes past the array are dropped.
  // Loaded values saturate into the VALUE_BITS range.
  // ---------------------------------------------------------------------------------------
  assign in_stall_o = (st_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign row_ok     = (32'(row_i) < MAX_UNKNOWNS);
  assign col_ok     = (32'(column_i) < MAX_UNKNOWNS);

  always_comb begin
    ev_ext = {{(EXT_W-32){entry_value_i[31]}}, entry_value_i};
    if ($signed(ev_ext) > $signed(VMAX_E)) begin
      ev_sat = VMAX_V;
    end else if ($signed(ev_ext) < $signed(VMIN_E)) begin
      ev_sat = VMIN_V;
    end else begin
      ev_sat = ev_ext[V-1:0];
    end
  end

  assign coef_we    = in_acc && (action_i == jls_pkg::ACT_COEF) && row_ok && col_ok;
  assign rhs_we     = in_acc && (action_i == jls_pkg::ACT_RHS) && row_ok;
  assign coef_waddr = {IDX_W'(row_i), IDX_W'(column_i)};
  assign coef_raddr = {i_q, j_q};
  // Sweeps read x[j]; emission reads x[i]; both from the current bank.
  assign est_raddr  = (st_q == ST_ERD) ? {bank_q, i_q} : {bank_q, j_q};
  assign est_we     = (st_q == ST_WR);

  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= ev_sat;
    end
    coef_rd <= coef_mem[coef_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rhs_we) begin
      rhs_mem[IDX_W'(row_i)] <= ev_sat;
    end
    rhs_rd <= rhs_mem[i_q];
  end

  // Two banks: the new vector goes to the other bank, and a bank swap replaces the copy.
  always_ff @(posedge clk_i) begin
    if (est_we) begin
      est_mem[{!bank_q, i_q}] <= res_q;
    end
    est_rd <= est_mem[est_raddr];
  end

  // ---------------------------------------------------------------------------------------
  // Arithmetic around the shared unit.
  // ---------------------------------------------------------------------------------------
  // Until the first sweep finishes the current vector is all zero.
  assign x_cur    = first_q ? '0 : est_rd;
  assign x_mag    = x_cur[V-1] ? (~x_cur + 1'b1) : x_cur;
  assign coef_mag = coef_rd[V-1] ? (~coef_rd + 1'b1) : coef_rd;
  assign res_mag  = res_q[V-1] ? (~res_q + 1'b1) : res_q;
  assign diag_mag = diag_q[V-1] ? (~diag_q + 1'b1) : diag_q;
  // Negative results may reach one step further than positive ones.
  assign lim_v    = neg_q ? VMIN_V : VMAX_V;

  // Product: drop the fraction bits, clamp, apply sign.
  always_comb begin
    mul_pm  = unit_res[2*V-1:jls_pkg::FRAC_BITS];
    mul_mag = (mul_pm > (2*V-16)'(lim_v)) ? lim_v : mul_pm[V-1:0];
    prod_s  = neg_q ? (~mul_mag + 1'b1) : mul_mag;
  end

  // Quotient: clamp, apply sign.
  always_comb begin
    div_q   = unit_res[NW-1:0];
    div_mag = (div_q > NW'(lim_v)) ? lim_v : div_q[V-1:0];
    quot_s  = neg_q ? (~div_mag + 1'b1) : div_mag;
  end

  assign num_w   = {{(ACC_W-V){rhs_rd[V-1]}}, rhs_rd} - acc_q;
  assign num_mag = num_w[ACC_W-1] ? (~num_w + 1'b1) : num_w;

  // Square and norm sum both saturate at 64 bits.
  always_comb begin
    sq_ext = SQ_W'(unit_res[2*V-1:0]);
    sq64   = (sq_ext > SQ_W'(64'hFFFF_FFFF_FFFF_FFFF)) ? '1 : sq_ext[63:0];
    s_sum  = {1'b0, s_q} + {1'b0, sq64};
    s_d    = s_sum[64] ? '1 : s_sum[63:0];
  end

  assign new_norm   = unit_res[31:0];
  assign norm_diff  = (prev_norm_q > new_norm) ? (prev_norm_q - new_norm)
                                               : (new_norm - prev_norm_q);
  assign conv_hit   = (norm_diff < 32'(tol_q));
  assign last_sweep = ((sweep_q + 16'd1) == maxit_q);

  always_comb begin
    sz_eff = (size_q == 5'd0) ? 5'd1 : size_q;
    n_eff  = (sz_eff > CAP_V) ? CAP_V : sz_eff;
    n_m1_d = IDX_W'(n_eff - 5'd1);
  end

  // Unit commands: one start pulse per operation.
  always_comb begin
    unit_cmd.start = 1'b0;
    unit_cmd.op    = jls_pkg::OP_MUL;
    unit_a         = A_W'(coef_mag);
    unit_b         = x_mag;
    unique case (st_q)
      ST_OP: begin
        unit_cmd.start = (j_q != i_q) && !first_q;
      end
      ST_NUM: begin
        unit_cmd.start = (diag_q != '0);
        unit_cmd.op    = jls_pkg::OP_DIV;
        unit_a         = A_W'({num_mag, {jls_pkg::FRAC_BITS{1'b0}}});
        unit_b         = diag_mag;
      end
      ST_WR: begin
        unit_cmd.start = 1'b1;
        unit_a         = A_W'(res_mag);
        unit_b         = res_mag;
      end
      ST_NORM: begin
        unit_cmd.start = 1'b1;
        unit_cmd.op    = jls_pkg::OP_SQRT;
        unit_a         = A_W'(s_q);
      end
      default: unit_cmd.start = 1'b0;
    endcase
  end

  jls_unit #(
    .V  (V),
    .NW (NW)
  ) u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (unit_cmd),
    .a_i    (unit_a),
    .b_i    (unit_b),
    .done_o (unit_done),
    .res_o  (unit_res)
  );

  // ---------------------------------------------------------------------------------------
  // Sequencer: rows i, columns j, sweeps, then emission.
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      n_m1_q      <= '0;
      bank_q      <= 1'b0;
      first_q     <= 1'b1;
      neg_q       <= 1'b0;
      conv_q      <= 1'b0;
      fault_q     <= 1'b0;
      acc_q       <= '0;
      diag_q      <= '0;
      res_q       <= '0;
      s_q         <= '0;
      prev_norm_q <= '0;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
      out_val_q   <= '0;
    end else begin
      unique case (st_q)
        ST_IDLE: begin
          if (in_acc && (action_i == jls_pkg::ACT_SOLVE)) begin
            n_m1_q      <= n_m1_d;
            i_q         <= '0;
            j_q         <= '0;
            acc_q       <= '0;
            s_q         <= '0;
            prev_norm_q <= '0;
            sweep_q     <= '0;
            conv_q      <= 1'b0;
            fault_q     <= 1'b0;
            first_q     <= 1'b1;
            bank_q      <= 1'b0;
            // No sweeps allowed: hand out the zero vector at once.
            st_q        <= (maxit_q == 16'd0) ? ST_ERD : ST_RD;
          end
        end
        ST_RD: st_q <= ST_OP;
        ST_OP: begin
          neg_q <= coef_rd[V-1] ^ x_cur[V-1];
          if (j_q == i_q) begin
            diag_q <= coef_rd;
          end
          if ((j_q != i_q) && !first_q) begin
            st_q <= ST_MUL;
          end else if (j_q == n_m1_q) begin
            st_q <= ST_NUM;
          end else begin
            j_q  <= j_q + 1'b1;
            st_q <= ST_RD;
          end
        end
        ST_MUL: begin
          if (unit_done) begin
            acc_q <= acc_q + {{(ACC_W-V){prod_s[V-1]}}, prod_s};
            if (j_q == n_m1_q) begin
              st_q <= ST_NUM;
            end else begin
              j_q  <= j_q + 1'b1;
              st_q <= ST_RD;
            end
          end
        end
        ST_NUM: begin
          neg_q <= num_w[ACC_W-1] ^ diag_q[V-1];
          if (diag_q == '0) begin
            // Zero diagonal: flag it and saturate toward the numerator's sign.
            fault_q <= 1'b1;
            if (num_w[ACC_W-1]) begin
              res_q <= VMIN_V;
            end else if (num_w != '0) begin
              res_q <= VMAX_V;
            end else begin
              res_q <= '0;
            end
            st_q <= ST_WR;
          end else begin
            st_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (unit_done) begin
            res_q <= quot_s;
            st_q  <= ST_WR;
          end
        end
        ST_WR: st_q <= ST_SQ;
        ST_SQ: begin
          if (unit_done) begin
            s_q <= s_d;
            if (i_q == n_m1_q) begin
              st_q <= ST_NORM;
            end else begin
              i_q   <= i_q + 1'b1;
              j_q   <= '0;
              acc_q <= '0;
              st_q  <= ST_RD;
            end
          end
        end
        ST_NORM: st_q <= ST_SQRT;
        ST_SQRT: begin
          if (unit_done) begin
            // The new vector becomes current; its norm is the next sweep's old norm.
            prev_norm_q <= new_norm;
            bank_q      <= !bank_q;
            first_q     <= 1'b0;
            sweep_q     <= sweep_q + 16'd1;
            conv_q      <= conv_hit;
            i_q         <= '0;
            j_q         <= '0;
            acc_q       <= '0;
            s_q         <= '0;
            st_q        <= (conv_hit || last_sweep) ? ST_ERD : ST_RD;
          end
        end
        ST_ERD: st_q <= ST_EOUT;
        ST_EOUT: begin
          out_val_q   <= out_sat;
          out_valid_q <= 1'b1;
          st_q        <= ST_EHOLD;
        end
        ST_EHOLD: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            if (i_q == n_m1_q) begin
              st_q <= ST_IDLE;
            end else begin
              i_q  <= i_q + 1'b1;
              st_q <= ST_ERD;
            end
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  // Solution elements saturate to the 32-bit output.
  always_comb begin
    xo_ext = {{(EXT_W-V){x_cur[V-1]}}, x_cur};
    if ($signed(xo_ext) > $signed(OMAX_E)) begin
      out_sat = 32'h7FFF_FFFF;
    end else if ($signed(xo_ext) < $signed(OMIN_E)) begin
      out_sat = 32'h8000_0000;
    end else begin
      out_sat = xo_ext[31:0];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign solution_value_o  = out_val_q;
  assign index_o           = 4'(i_q);
  assign last_o            = (i_q == n_m1_q);
  assign converged_o       = conv_q;
  assign divide_fault_o    = fault_q;
  assign iterations_used_o = sweep_q;

  `JLS_ASSERT(a_out_only_emit, out_valid_o |-> (st_q == ST_EHOLD), "result outside emission")
  `JLS_ASSERT(a_ready_no_out, !in_stall_o |-> !out_valid_o, "ready while result pending")
  `JLS_ASSERT(a_last_to_idle, (out_valid_o && last_o && !out_stall_i) |=> !in_stall_o, "no idle after last")
  `JLS_ASSERT(a_iter_limit, out_valid_o |-> (iterations_used_o <= maxit_q), "sweep limit exceeded")

endmodule
